// ===== hw/rtl/single_bin_dft_correlator_assert.svh =====
// Assertion macros used by the correlator checker.
`ifndef SINGLE_BIN_DFT_CORRELATOR_ASSERT_SVH
`define SINGLE_BIN_DFT_CORRELATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SBDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SBDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sbdc_pkg.sv =====
// Shared types and constants of the single-bin DFT correlator.
package sbdc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 32;
  localparam int SUM_W      = 48;
  localparam int MEAN_W     = 16;
  localparam int COUNT_W    = 17;
  localparam int PHASE_W    = 32;
  localparam int MEAN_SHIFT = 15;

  localparam int MAX_SAMPLES_DEF   = 65536;
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int JOB_Q_DEPTH       = 4;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [COUNT_W-1:0]        count_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_beat_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_real;
    logic signed [MEAN_W-1:0] mean_imag;
    count_t                   samples_used;
    logic                     count_overflow;
  } out_beat_t;

  // One classified sample on its way from front to back.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       acc_en;
    logic                       last;
  } job_t;

  // Finished block handed to the divider.
  typedef struct packed {
    sum_t   sum_real;
    sum_t   sum_imag;
    count_t count;
    logic   ovf;
  } div_req_t;

endpackage

// ===== hw/rtl/sbdc_fifo.sv =====
// Small register queue between the front and back halves.
module sbdc_fifo #(
  parameter int DW    = $bits(sbdc_pkg::job_t) + $clog2(sbdc_pkg::TABLE_ENTRIES_DEF),
  parameter int DEPTH = sbdc_pkg::JOB_Q_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          full,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [AW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sbdc_front.sv =====
// Front end: phase accumulator, sample count limit and job classification.
module sbdc_front #(
  parameter int TABLE_ENTRIES = sbdc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_SAMPLES   = sbdc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sbdc_pkg::PHASE_W-1:0]      cfg_wdata,
  input  logic                              push,
  input  sbdc_pkg::in_beat_t                in_beat,
  input  logic                              q_full,
  output logic                              job_push,
  output sbdc_pkg::job_t                    job,
  output logic [$clog2(TABLE_ENTRIES)-1:0]  job_idx
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [sbdc_pkg::PHASE_W-1:0] step_r;
  logic [sbdc_pkg::PHASE_W-1:0] phase_r;
  logic [sbdc_pkg::PHASE_W-1:0] phase_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_nxt;
  logic                         acc_en;

  assign job_push = push && !q_full;
  // saturated count: sample passes through for phase but is not summed
  assign acc_en   = (cnt_r != CNT_W'(MAX_SAMPLES));
  assign job_idx  = phase_r[sbdc_pkg::PHASE_W-1 -: IDX_W];

  always_comb begin
    job.sample = in_beat.sample;
    job.acc_en = acc_en;
    job.last   = in_beat.last;
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    if (job_push) begin
      if (in_beat.last) begin
        phase_nxt = '0;
        cnt_nxt   = '0;
      end else begin
        phase_nxt = phase_r + step_r;
        cnt_nxt   = acc_en ? cnt_r + CNT_W'(1) : cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      phase_r <= '0;
      cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        step_r <= cfg_wdata;
      end
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/sbdc_back.sv =====
// Back end: quarter-wave ROM lookup, complex multiply and block accumulation.
module sbdc_back #(
  parameter int TABLE_ENTRIES = sbdc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_SAMPLES   = sbdc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  sbdc_pkg::job_t                    q_job,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]  q_idx,
  output logic                              q_pop,
  input  logic                              div_free,
  output logic                              div_load,
  output sbdc_pkg::div_req_t                div_req
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int QN     = TABLE_ENTRIES / 4;
  localparam int QDEPTH = QN + 1;
  localparam int QA_W   = $clog2(QDEPTH);
  localparam int QV_W   = sbdc_pkg::COEF_W - 1;
  localparam int COEF_W = sbdc_pkg::COEF_W;
  localparam int PROD_W = sbdc_pkg::PROD_W;
  localparam int SUM_W  = sbdc_pkg::SUM_W;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  // sin(pi/2 * u / N) in Q15, Taylor series in Q30, eleven terms
  function automatic logic [QV_W-1:0] quarter_sine(input int unsigned u);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (sbdc_pkg::HALF_PI_Q30 * 64'(u)) / 64'(TABLE_ENTRIES);
    x2   = (x * x) >> 30;
    term = x;
    acc  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  acc = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  acc = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; acc = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; acc = acc + signed'(term);
    term = ((term * x2) >> 30) / 64'd342; acc = acc - signed'(term);
    term = ((term * x2) >> 30) / 64'd420; acc = acc + signed'(term);
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 64'sd32767) begin
      acc = 64'sd32767;
    end
    return acc[QV_W-1:0];
  endfunction

  function automatic logic [QDEPTH*QV_W-1:0] build_qtab();
    logic [QDEPTH*QV_W-1:0] t;
    t = '0;
    for (int j = 0; j < QDEPTH; j++) begin
      t[j*QV_W +: QV_W] = quarter_sine(4 * j);
    end
    return t;
  endfunction

  localparam logic [QDEPTH*QV_W-1:0] QTAB = build_qtab();

  logic                      advance;
  logic [QA_W-1:0]           addr_a;
  logic [QA_W-1:0]           addr_b;

  // stage 1: ROM read
  logic                      s1_vld_r;
  sbdc_pkg::job_t            s1_job_r;
  quad_t                     s1_quad_r;
  logic [QV_W-1:0]           rom_a_r;
  logic [QV_W-1:0]           rom_b_r;

  // stage 2: products
  logic signed [COEF_W-1:0]  pos_a;
  logic signed [COEF_W-1:0]  pos_b;
  logic signed [COEF_W-1:0]  cos_c;
  logic signed [COEF_W-1:0]  sin_c;
  logic signed [PROD_W-1:0]  pre_nxt;
  logic signed [PROD_W-1:0]  pim_nxt;
  logic                      s2_vld_r;
  logic                      s2_acc_en_r;
  logic                      s2_last_r;
  logic signed [PROD_W-1:0]  s2_pre_r;
  logic signed [PROD_W-1:0]  s2_pim_r;

  // stage 3: accumulators
  sbdc_pkg::sum_t            sum_re_r;
  sbdc_pkg::sum_t            sum_im_r;
  logic [CNT_W-1:0]          cnt_r;
  logic                      ovf_r;
  sbdc_pkg::sum_t            fin_re;
  sbdc_pkg::sum_t            fin_im;
  logic [CNT_W-1:0]          fin_cnt;
  logic                      fin_ovf;

  // hold everything while a block end waits for the divider
  assign advance = !(s2_vld_r && s2_last_r && !div_free);
  assign q_pop   = advance && !q_empty;

  assign addr_a = QA_W'(q_idx[IDX_W-3:0]);
  assign addr_b = QA_W'(QN) - addr_a;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_job_r  <= q_job;
      s1_quad_r <= quad_t'(q_idx[IDX_W-1 -: 2]);
      rom_a_r   <= QTAB[addr_a*QV_W +: QV_W];
      rom_b_r   <= QTAB[addr_b*QV_W +: QV_W];
    end
  end

  always_comb begin
    pos_a = signed'({1'b0, rom_a_r});
    pos_b = signed'({1'b0, rom_b_r});
    case (s1_quad_r)
      QUAD_0:  begin sin_c = pos_a;  cos_c = pos_b;  end
      QUAD_1:  begin sin_c = pos_b;  cos_c = -pos_a; end
      QUAD_2:  begin sin_c = -pos_a; cos_c = -pos_b; end
      QUAD_3:  begin sin_c = -pos_b; cos_c = pos_a;  end
      default: begin sin_c = pos_a;  cos_c = pos_b;  end
    endcase
    pre_nxt = s1_job_r.sample * cos_c;
    pim_nxt = s1_job_r.sample * sin_c;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_acc_en_r <= s1_job_r.acc_en;
      s2_last_r   <= s1_job_r.last;
      s2_pre_r    <= pre_nxt;
      s2_pim_r    <= pim_nxt;
    end
  end

  always_comb begin
    fin_re  = sum_re_r;
    fin_im  = sum_im_r;
    fin_cnt = cnt_r;
    fin_ovf = ovf_r;
    if (s2_acc_en_r) begin
      fin_re  = sum_re_r + SUM_W'(s2_pre_r);
      fin_im  = sum_im_r + SUM_W'(s2_pim_r);
      fin_cnt = cnt_r + CNT_W'(1);
    end else begin
      fin_ovf = 1'b1;
    end
  end

  assign div_load         = advance && s2_vld_r && s2_last_r;
  assign div_req.sum_real = fin_re;
  assign div_req.sum_imag = fin_im;
  assign div_req.count    = sbdc_pkg::count_t'(fin_cnt);
  assign div_req.ovf      = fin_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      sum_re_r <= '0;
      sum_im_r <= '0;
      cnt_r    <= '0;
      ovf_r    <= 1'b0;
    end else if (advance) begin
      s1_vld_r <= !q_empty;
      s2_vld_r <= s1_vld_r;
      if (s2_vld_r) begin
        if (s2_last_r) begin
          sum_re_r <= '0;
          sum_im_r <= '0;
          cnt_r    <= '0;
          ovf_r    <= 1'b0;
        end else begin
          sum_re_r <= fin_re;
          sum_im_r <= fin_im;
          cnt_r    <= fin_cnt;
          ovf_r    <= fin_ovf;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/sbdc_div.sv =====
// Block-end divider: two radix-2 restoring dividers and the result register.
module sbdc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sbdc_pkg::div_req_t    req,
  output logic                  free,
  output logic                  empty,
  input  logic                  pop,
  output sbdc_pkg::out_beat_t   out_beat
);

  localparam int SUM_W   = sbdc_pkg::SUM_W;
  localparam int COUNT_W = sbdc_pkg::COUNT_W;
  localparam int MEAN_W  = sbdc_pkg::MEAN_W;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam logic signed [SUM_W-1:0] MEAN_HI = SUM_W'((2 ** (MEAN_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] MEAN_LO = -MEAN_HI - SUM_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // truncated quotient with sign restored, then floor by 2^15, then clamp
  function automatic logic signed [MEAN_W-1:0] finish_mean(
    input logic [SUM_W-1:0] mag,
    input logic             neg
  );
    logic signed [SUM_W-1:0] q;
    logic signed [SUM_W-1:0] m;
    q = neg ? -signed'(mag) : signed'(mag);
    m = q >>> sbdc_pkg::MEAN_SHIFT;
    if (m > MEAN_HI) begin
      m = MEAN_HI;
    end else if (m < MEAN_LO) begin
      m = MEAN_LO;
    end
    return signed'(m[MEAN_W-1:0]);
  endfunction

  state_t               state_r;
  state_t               state_nxt;
  logic [STEP_W-1:0]    step_r;
  logic [SUM_W-1:0]     dvd_re_r;
  logic [SUM_W-1:0]     dvd_im_r;
  logic [COUNT_W-1:0]   rem_re_r;
  logic [COUNT_W-1:0]   rem_im_r;
  sbdc_pkg::count_t     dvs_r;
  logic                 neg_re_r;
  logic                 neg_im_r;
  logic                 ovf_r;
  logic                 out_vld_r;
  sbdc_pkg::out_beat_t  out_r;
  logic                 slot_free;
  logic                 last_step;

  logic [COUNT_W:0]     sh_re;
  logic [COUNT_W:0]     sh_im;
  logic [COUNT_W+1:0]   diff_re;
  logic [COUNT_W+1:0]   diff_im;
  logic                 ge_re;
  logic                 ge_im;

  assign free      = (state_r == ST_IDLE);
  assign empty     = !out_vld_r;
  assign out_beat  = out_r;
  assign slot_free = !out_vld_r || pop;
  assign last_step = (step_r == STEP_W'(SUM_W - 1));

  // one quotient bit per cycle for each of the two sums
  always_comb begin
    sh_re   = {rem_re_r, dvd_re_r[SUM_W-1]};
    sh_im   = {rem_im_r, dvd_im_r[SUM_W-1]};
    diff_re = {1'b0, sh_re} - {2'b00, dvs_r};
    diff_im = {1'b0, sh_im} - {2'b00, dvs_r};
    ge_re   = !diff_re[COUNT_W+1];
    ge_im   = !diff_im[COUNT_W+1];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (load)      state_nxt = ST_RUN;
      ST_RUN:  if (last_step) state_nxt = ST_FIN;
      ST_FIN:  if (slot_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          step_r   <= '0;
          dvd_re_r <= req.sum_real[SUM_W-1] ? -req.sum_real : req.sum_real;
          dvd_im_r <= req.sum_imag[SUM_W-1] ? -req.sum_imag : req.sum_imag;
          neg_re_r <= req.sum_real[SUM_W-1];
          neg_im_r <= req.sum_imag[SUM_W-1];
          rem_re_r <= '0;
          rem_im_r <= '0;
          dvs_r    <= req.count;
          ovf_r    <= req.ovf;
        end
      end
      ST_RUN: begin
        step_r   <= step_r + STEP_W'(1);
        dvd_re_r <= {dvd_re_r[SUM_W-2:0], ge_re};
        dvd_im_r <= {dvd_im_r[SUM_W-2:0], ge_im};
        rem_re_r <= ge_re ? diff_re[COUNT_W-1:0] : sh_re[COUNT_W-1:0];
        rem_im_r <= ge_im ? diff_im[COUNT_W-1:0] : sh_im[COUNT_W-1:0];
      end
      default: begin
        step_r <= step_r;
      end
    endcase
    if (state_r == ST_FIN && slot_free) begin
      out_r.mean_real      <= finish_mean(dvd_re_r, neg_re_r);
      out_r.mean_imag      <= finish_mean(dvd_im_r, neg_im_r);
      out_r.samples_used   <= dvs_r;
      out_r.count_overflow <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && slot_free) begin
        out_vld_r <= 1'b1;
      end else if (pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/single_bin_dft_correlator.sv =====
// Single-bin DFT correlator top level: front end, job queue, MAC back end, divider.
// Throughput: one sample beat per cycle while the job queue is not full; block ends
//   go through the divider one at a time (load, 48 steps, finish), and an unpopped result holds it too.
// From last sample accepted to result visible: ROM read, multiply, divider load,
//   48 divider steps, finish; the 48-bit divider takes the longest.
// Reset (rst_n low, synchronous): phase step, phase, sums and counts to zero.
module single_bin_dft_correlator #(
  parameter int TABLE_ENTRIES = sbdc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_SAMPLES   = sbdc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample beats in
  input  logic                          push,
  output logic                          full,
  input  sbdc_pkg::in_beat_t            in_beat,
  // result beats out
  output logic                          empty,
  input  logic                          pop,
  output sbdc_pkg::out_beat_t           out_beat,
  // phase step register
  input  logic                          cfg_we,
  input  logic [sbdc_pkg::PHASE_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int JOB_W = $bits(sbdc_pkg::job_t);
  localparam int Q_DW  = JOB_W + IDX_W;

  // front -> queue
  logic                job_push;
  sbdc_pkg::job_t      job;
  logic [IDX_W-1:0]    job_idx;

  // queue -> back
  logic                q_full;
  logic                q_empty;
  logic                q_pop;
  logic [Q_DW-1:0]     q_rdata;
  sbdc_pkg::job_t      q_job;
  logic [IDX_W-1:0]    q_idx;

  // back -> divider
  logic                div_free;
  logic                div_load;
  sbdc_pkg::div_req_t  div_req;

  // The queue is the only back-pressure the input sees: a full queue means the
  // back end is parked on a block end waiting for the divider.
  assign full = q_full;

  // Front: owns phase_step and the per-block phase and sample count. Each beat
  // leaves here tagged with its table index and whether it is summed.
  sbdc_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_SAMPLES   (MAX_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .in_beat   (in_beat),
    .q_full    (q_full),
    .job_push  (job_push),
    .job       (job),
    .job_idx   (job_idx)
  );

  sbdc_fifo #(
    .DW    (Q_DW),
    .DEPTH (sbdc_pkg::JOB_Q_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata ({job, job_idx}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign q_job = sbdc_pkg::job_t'(q_rdata[Q_DW-1 -: JOB_W]);
  assign q_idx = q_rdata[IDX_W-1:0];

  // Back: quarter-wave ROM (two registered reads), cos/sin products, 48-bit
  // sums. A block end is handed to the divider with the sums cleared behind it.
  sbdc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_SAMPLES   (MAX_SAMPLES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_job    (q_job),
    .q_idx    (q_idx),
    .q_pop    (q_pop),
    .div_free (div_free),
    .div_load (div_load),
    .div_req  (div_req)
  );

  // Divider: sum / n toward zero, floor by 2^15, into the one-beat output reg.
  sbdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .req      (div_req),
    .free     (div_free),
    .empty    (empty),
    .pop      (pop),
    .out_beat (out_beat)
  );

endmodule

// ===== hw/rtl/sbdc_checker.sv =====
// Port-level checker for the correlator, bound to the top level.
`include "single_bin_dft_correlator_assert.svh"

module sbdc_checker #(
  parameter int MAX_SAMPLES = sbdc_pkg::MAX_SAMPLES_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 push,
  input logic                 full,
  input sbdc_pkg::in_beat_t   in_beat,
  input logic                 empty,
  input logic                 pop,
  input sbdc_pkg::out_beat_t  out_beat
);

  localparam int PEND_W = 4;

  logic              last_in;
  logic              res_out;
  logic [PEND_W-1:0] pend_r;

  assign last_in = push && !full && in_beat.last;
  assign res_out = pop && !empty;

  // block ends taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({last_in, res_out})
        2'b10:   pend_r <= pend_r + PEND_W'(1);
        2'b01:   pend_r <= pend_r - PEND_W'(1);
        default: pend_r <= pend_r;
      endcase
    end
  end

  `SBDC_ASSERT_NOW(a_result_has_block, res_out, pend_r != '0, "result without a block end")
  `SBDC_ASSERT_NOW(a_count_in_range, !empty, (out_beat.samples_used != '0) && (out_beat.samples_used <= sbdc_pkg::count_t'(MAX_SAMPLES)), "samples_used out of range")
  `SBDC_ASSERT_NOW(a_ovf_saturates, !empty && out_beat.count_overflow, out_beat.samples_used == sbdc_pkg::count_t'(MAX_SAMPLES), "overflow without saturated count")
  `SBDC_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_beat), "result dropped or changed while stalled")

endmodule

bind single_bin_dft_correlator sbdc_checker #(
  .MAX_SAMPLES (MAX_SAMPLES)
) u_sbdc_checker (.*);
